[rtl/lrp_pkg.sv]
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared widths, defaults and controller/datapath interface types for the
// loss run probability block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrp_pkg;

  localparam int unsigned PROB_W  = 32;
  localparam int unsigned TRIAL_W = 20;
  localparam int unsigned RUN_W   = 10;
  localparam int unsigned IN_W    = 64;
  localparam int unsigned OUT_W   = 32;

  localparam logic [PROB_W-1:0] Q_ONE = 32'h8000_0000;

  localparam logic [15:0] MAX_RUN_DEF    = 16'd1023;
  localparam int          RING_DEPTH_DEF = 2048;
  localparam logic [31:0] MAX_TRIALS_DEF = 32'd1048575;

  typedef struct packed {
    logic load;
    logic pow_mul;
    logic pow_upd;
    logic cp_mul;
    logic cp_upd;
    logic st_rd;
    logic st_mul;
    logic st_acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pow_done;
    logic step_done;
    logic short_run;
  } status_t;

endpackage

`default_nettype wire

[rtl/lrp_ctrl.sv]
// ----------------------------------------------------------------------------
// lrp_ctrl
// Sequencer for the power loop, the recurrence steps and the output
// transaction of the loss run probability block.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  lrp_pkg::status_t  status_i,
  output lrp_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StPowMul  = 4'd1;
  localparam logic [3:0] StPowUpd  = 4'd2;
  localparam logic [3:0] StCpMul   = 4'd3;
  localparam logic [3:0] StCpUpd   = 4'd4;
  localparam logic [3:0] StStepRd  = 4'd5;
  localparam logic [3:0] StStepMul = 4'd6;
  localparam logic [3:0] StStepAcc = 4'd7;
  localparam logic [3:0] StFinish  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StPowMul;
        end
      end
      StPowMul: begin
        if (status_i.pow_done) begin
          state_d = StCpMul;
        end else begin
          cmd_o.pow_mul = 1'b1;
          state_d       = StPowUpd;
        end
      end
      StPowUpd: begin
        cmd_o.pow_upd = 1'b1;
        state_d       = StPowMul;
      end
      StCpMul: begin
        cmd_o.cp_mul = 1'b1;
        state_d      = StCpUpd;
      end
      StCpUpd: begin
        cmd_o.cp_upd = 1'b1;
        state_d      = StStepRd;
      end
      StStepRd: begin
        if (status_i.short_run || status_i.step_done) begin
          state_d = StFinish;
        end else begin
          cmd_o.st_rd = 1'b1;
          state_d     = StStepMul;
        end
      end
      StStepMul: begin
        cmd_o.st_mul = 1'b1;
        state_d      = StStepAcc;
      end
      StStepAcc: begin
        cmd_o.st_acc = 1'b1;
        state_d      = StStepRd;
      end
      StFinish: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lrp_datapath.sv]
// ----------------------------------------------------------------------------
// lrp_datapath
// Shared Q1.31 multiplier, recurrence accumulator, history ring memory and
// result register of the loss run probability block.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_datapath #(
  parameter logic [15:0] MAX_RUN    = lrp_pkg::MAX_RUN_DEF,
  parameter int          RING_DEPTH = lrp_pkg::RING_DEPTH_DEF,
  parameter logic [31:0] MAX_TRIALS = lrp_pkg::MAX_TRIALS_DEF
) (
  input  wire                              clk_i,
  input  wire [lrp_pkg::PROB_W-1:0]        win_prob_i,
  input  wire [lrp_pkg::TRIAL_W-1:0]       trial_count_i,
  input  wire [lrp_pkg::RUN_W-1:0]         run_length_i,
  input  lrp_pkg::cmd_t                    cmd_i,
  output lrp_pkg::status_t                 status_o,
  output logic [lrp_pkg::OUT_W-1:0]        run_prob_o
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = lrp_pkg::PROB_W;
  localparam int TW = lrp_pkg::TRIAL_W;
  localparam int RW = lrp_pkg::RUN_W;

  logic [PW-1:0] p_q, omp_q, c_q, cp_q, v_q, prod_q, rdata_q, res_q;
  logic [TW-1:0] trials_q, cnt_q;
  logic [RW-1:0] run_q;
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;

  logic [PW-1:0]   ring [RING_DEPTH];

  logic [PW-1:0]   p_clamp;
  logic [TW-1:0]   trials_clamp;
  logic [RW-1:0]   run_clamp;
  logic [PW-1:0]   mul_a, mul_b;
  logic [2*PW-1:0] mul_full;
  logic [PW:0]     sum, diff;
  logic [PW-1:0]   v_next;
  logic            ring_we;
  logic [PW-1:0]   ring_wdata;
  logic [AW-1:0]   wr_ptr_inc, rd_ptr_inc;

  assign p_clamp      = (win_prob_i > lrp_pkg::Q_ONE) ? lrp_pkg::Q_ONE : win_prob_i;
  assign trials_clamp = ({12'd0, trial_count_i} > MAX_TRIALS) ? MAX_TRIALS[TW-1:0]
                                                              : trial_count_i;
  assign run_clamp    = ({6'd0, run_length_i} > MAX_RUN) ? MAX_RUN[RW-1:0] : run_length_i;

  always_comb begin
    mul_a = c_q;
    mul_b = omp_q;
    if (cmd_i.cp_mul) begin
      mul_b = p_q;
    end else if (cmd_i.st_mul) begin
      mul_a = cp_q;
      mul_b = rdata_q;
    end
  end

  assign mul_full = mul_a * mul_b;

  assign sum    = {1'b0, v_q} + {1'b0, cp_q};
  assign diff   = (sum >= {1'b0, prod_q}) ? sum - {1'b0, prod_q} : '0;
  assign v_next = (diff > {1'b0, lrp_pkg::Q_ONE}) ? lrp_pkg::Q_ONE : diff[PW-1:0];

  assign wr_ptr_inc = (wr_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

  always_comb begin
    ring_we    = 1'b0;
    ring_wdata = v_next;
    priority if (cmd_i.pow_upd) begin
      ring_we    = 1'b1;
      ring_wdata = '0;
    end else if (cmd_i.cp_upd) begin
      ring_we    = 1'b1;
      ring_wdata = c_q;
    end else if (cmd_i.st_acc) begin
      ring_we    = 1'b1;
    end else begin
      ring_we    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[wr_ptr_q] <= ring_wdata;
    end
    if (cmd_i.st_rd) begin
      rdata_q <= ring[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q      <= p_clamp;
      omp_q    <= lrp_pkg::Q_ONE - p_clamp;
      trials_q <= trials_clamp;
      run_q    <= run_clamp;
      c_q      <= lrp_pkg::Q_ONE;
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end
    if (cmd_i.pow_mul || cmd_i.cp_mul || cmd_i.st_mul) begin
      prod_q <= mul_full[2*PW-2:PW-1];
    end
    if (cmd_i.pow_upd) begin
      c_q      <= prod_q;
      wr_ptr_q <= wr_ptr_inc;
      cnt_q    <= cnt_q + 1'b1;
    end
    if (cmd_i.cp_upd) begin
      cp_q     <= prod_q;
      v_q      <= c_q;
      wr_ptr_q <= wr_ptr_inc;
    end
    if (cmd_i.st_rd) begin
      rd_ptr_q <= rd_ptr_inc;
    end
    if (cmd_i.st_acc) begin
      v_q      <= v_next;
      wr_ptr_q <= wr_ptr_inc;
      cnt_q    <= cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      res_q <= status_o.short_run ? '0 : v_q;
    end
  end

  assign status_o.pow_done  = (cnt_q == TW'(run_q));
  assign status_o.step_done = (cnt_q == trials_q);
  assign status_o.short_run = (trials_q < TW'(run_q));

  assign run_prob_o = res_q;

endmodule

`default_nettype wire

[rtl/loss_run_probability.sv]
// ----------------------------------------------------------------------------
// loss_run_probability
// Probability of a run of L losses within N Bernoulli trials, Q1.31.
// Sequence: power steps, a c*p step, then recurrence steps up to the result
//   (no recurrence steps when N < L), all on the single shared 32x32 multiplier
//   (each power step is a multiply and an update; each recurrence step is a
//   ring read, multiply, accumulate and write).
// Intake: one item at a time; a new item is taken while the result waits.
// Reset: clears controller state and output valid; ring contents stay
//   undefined and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module loss_run_probability #(
  parameter logic [15:0] MAX_RUN    = lrp_pkg::MAX_RUN_DEF,
  parameter int          RING_DEPTH = lrp_pkg::RING_DEPTH_DEF,
  parameter logic [31:0] MAX_TRIALS = lrp_pkg::MAX_TRIALS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // win_prob[31:0], trial_count[51:32], run_length[61:52], zero pad[63:62]
  input  wire [lrp_pkg::IN_W-1:0]    s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire                        m_axis_tready_i,
  // run_prob[31:0]
  output logic [lrp_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  lrp_pkg::cmd_t    cmd;
  lrp_pkg::status_t status;

  lrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lrp_datapath #(
    .MAX_RUN    (MAX_RUN),
    .RING_DEPTH (RING_DEPTH),
    .MAX_TRIALS (MAX_TRIALS)
  ) u_datapath (
    .clk_i         (clk_i),
    .win_prob_i    (s_axis_tdata_i[31:0]),
    .trial_count_i (s_axis_tdata_i[51:32]),
    .run_length_i  (s_axis_tdata_i[61:52]),
    .cmd_i         (cmd),
    .status_o      (status),
    .run_prob_o    (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

[bench/run_prob_monitor.sv]
// ----------------------------------------------------------------------------
// run_prob_monitor
// Watches both stream channels of loss_run_probability. Each accepted input
// transaction runs through a Q1.31 model of the power and recurrence steps;
// each accepted result is compared with the oldest predicted run probability.
// ----------------------------------------------------------------------------
module run_prob_monitor
  import lrp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  // win_prob[31:0], trial_count[51:32], run_length[61:52], zero pad[63:62]
  input  logic [IN_W-1:0]   s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  // run_prob[31:0]
  input  logic [OUT_W-1:0]  m_tdata_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PROB_W-1:0] loss_history [RING_DEPTH_DEF];
  logic [PROB_W-1:0] awaited_run_prob [$];
  int                mismatches = 0;
  int                awaiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = awaiting;

  function automatic logic [PROB_W-1:0] q_product(input logic [PROB_W-1:0] a,
                                                  input logic [PROB_W-1:0] b);
    logic [63:0] wide;
    wide = {32'd0, a} * {32'd0, b};
    return wide[62:31];
  endfunction

  function automatic logic [PROB_W-1:0] run_probability(input logic [IN_W-1:0] item);
    logic [PROB_W-1:0] p;
    logic [PROB_W-1:0] c;
    logic [PROB_W-1:0] cp;
    logic [PROB_W-1:0] prev;
    logic [PROB_W-1:0] old;
    logic [PROB_W-1:0] sub;
    logic [33:0]       acc;
    logic [31:0]       trials;
    logic [31:0]       run;
    longint unsigned   n;
    int unsigned       k;
    p      = item[31:0];
    trials = {12'd0, item[51:32]};
    run    = {22'd0, item[61:52]};
    if (p > Q_ONE) p = Q_ONE;
    if (run > MAX_RUN_DEF) run = 32'(MAX_RUN_DEF);
    if (trials > MAX_TRIALS_DEF) trials = MAX_TRIALS_DEF;
    c = Q_ONE;
    for (k = 0; k < run; k++) c = q_product(c, Q_ONE - p);
    cp = q_product(c, p);
    for (n = 0; n <= trials; n++) begin
      if (n < run) begin
        loss_history[n % RING_DEPTH_DEF] = '0;
      end else if (n == run) begin
        loss_history[n % RING_DEPTH_DEF] = c;
      end else begin
        prev = loss_history[(n - 1) % RING_DEPTH_DEF];
        old  = loss_history[(n - run - 1) % RING_DEPTH_DEF];
        sub  = q_product(cp, old);
        acc  = {2'b00, prev} + {2'b00, cp};
        acc  = (acc >= {2'b00, sub}) ? acc - {2'b00, sub} : '0;
        if (acc > {2'b00, Q_ONE}) acc = {2'b00, Q_ONE};
        loss_history[n % RING_DEPTH_DEF] = acc[31:0];
      end
    end
    return loss_history[trials % RING_DEPTH_DEF];
  endfunction

  always @(posedge clk_i) begin
    logic [PROB_W-1:0] want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) awaited_run_prob.push_back(run_probability(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_run_prob.size() == 0) begin
          $display("%0t run_prob: expected none, actual %h", $time, m_tdata_i);
          mismatches++;
        end else begin
          want = awaited_run_prob.pop_front();
          if (want !== m_tdata_i) begin
            $display("%0t run_prob: expected %h, actual %h", $time, want, m_tdata_i);
            mismatches++;
          end
        end
      end
      awaiting = awaited_run_prob.size();
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives loss_run_probability with directed corner items (zero and maximum
// run lengths, short trial counts, clamped and edge win probabilities, ring
// wrap, the largest trial count) and then random items under changing
// sender and receiver idling, including one long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lrp_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 125;
  localparam int unsigned PHASE_LEN      = 47;
  localparam int unsigned WATCHDOG_LIMIT = 12_000_000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned STALL_AT       = 100;
  localparam int unsigned STALL_CYCLES   = 4000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int fail_count;
  int pending;

  always #6 clk_i = ~clk_i;

  loss_run_probability DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  run_prob_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic offer_item(input logic [31:0] p, input logic [19:0] n, input logic [9:0] l);
    if (items_sent < PHASE_LEN) begin
      send_idle_pct = 10;
      recv_idle_pct = 75;
    end else if (items_sent < 2 * PHASE_LEN) begin
      send_idle_pct = 75;
      recv_idle_pct = 10;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, l, n, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic offer_random();
    logic [31:0] p;
    logic [19:0] n;
    logic [9:0]  l;
    int          mode;
    mode = $urandom_range(99);
    p    = $urandom_range(0, Q_ONE);
    l    = 10'($urandom_range(0, 16));
    n    = 20'($urandom_range(0, 80));
    if (mode < 15) begin
      l = 10'($urandom_range(0, 1023));
      n = 20'($urandom_range(l, l + 40));
    end else if (mode < 25) begin
      case ($urandom_range(4))
        0: p = '0;
        1: p = Q_ONE;
        2: p = Q_ONE - 1;
        3: p = 32'd1;
        default: p = $urandom | Q_ONE;
      endcase
    end else if (mode < 32 && items_sent < 80) begin
      l = 10'($urandom_range(0, 1023));
      n = 20'($urandom_range(2048, 4200));
    end else if (mode < 40) begin
      l = 10'($urandom_range(1, 1023));
      n = 20'($urandom_range(0, l - 1));
    end
    offer_item(p, n, l);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    offer_item(32'h0000_0000, 20'd0,    10'd0);
    offer_item(Q_ONE,         20'd10,   10'd0);
    offer_item(32'hC000_0000, 20'd12,   10'd0);
    offer_item(32'hFFFF_FFFF, 20'd5,    10'd3);
    offer_item(32'h0000_0000, 20'd10,   10'd10);
    offer_item(32'h0000_0000, 20'd20,   10'd5);
    offer_item(32'h4000_0000, 20'd3,    10'd7);
    offer_item(32'h0000_0000, 20'd1022, 10'd1023);
    offer_item(32'h0000_0000, 20'd1023, 10'd1023);
    offer_item(32'h0000_1000, 20'd1100, 10'd1023);
    offer_item(Q_ONE,         20'd30,   10'd2);
    offer_item(32'h7FFF_FFFF, 20'd40,   10'd1);
    offer_item(32'h4000_0000, 20'd200,  10'd1);
    offer_item(32'h0000_0001, 20'd40,   10'd4);
    offer_item(32'h2000_0000, 20'd1,    10'd1);
    offer_item(32'h5555_5555, 20'd2100, 10'd3);
    offer_item(32'h2AAA_AAAA, 20'hFFFFF, 10'd1023);
    repeat (RANDOM_ITEMS) offer_random();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int taken;
    bit stalled;
    taken   = 0;
    stalled = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (!stalled && taken >= STALL_AT) begin
        stalled = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
